// ----- hdl/dsq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsq_pkg;

  // Fixed field widths of the ports
  localparam int RAND_W    = 9;
  localparam int CFG_W     = 9;
  localparam int ROUGH_W   = 8;
  localparam int OUT_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUGHNESS   = 3'd3;

  // Register values after reset
  localparam logic [CFG_W-1:0]   RST_MAP_WIDTH   = 9'd64;
  localparam logic [CFG_W-1:0]   RST_MAP_HEIGHT  = 9'd64;
  localparam logic [CFG_W-1:0]   RST_LEVEL_COUNT = 9'd16;
  localparam logic [ROUGH_W-1:0] RST_ROUGHNESS   = 8'd4;

  // Last of the four neighbour read slots of one point
  localparam logic [1:0] READ_LAST = 2'd3;

  typedef enum logic [1:0] {
    PASS_SEED,
    PASS_SQUARE,
    PASS_DIAMOND
  } pass_e;

  // Walker to datapath: what kind of point comes next
  typedef struct packed {
    pass_e kind;
    logic  map_done;
  } walk_ctl_t;

  // One finished result in the output queue
  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] level;
    logic             in_map;
    logic             map_done;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/dsq_walker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsq_walker
  import dsq_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              restart_i,
  input  logic              step_i,
  input  logic [SIDE_W-1:0] side_mask_i,
  output logic [SIDE_W-1:0] col_o,
  output logic [SIDE_W-1:0] row_o,
  output logic [SIDE_W-1:0] half_o,
  output walk_ctl_t         ctl_o
);

  pass_e             pass_q, pass_d;
  logic [SIDE_W-1:0] half_step_q, half_step_d;
  logic [SIDE_W-1:0] cur_col_q, cur_col_d;
  logic [SIDE_W-1:0] cur_row_q, cur_row_d;
  logic              dia_half_q, dia_half_d;
  logic [1:0]        seed_cnt_q, seed_cnt_d;

  logic [SIDE_W-1:0] side_half;
  logic [SIDE_W-1:0] half_next;
  logic [SIDE_W:0]   col_step;
  logic [SIDE_W:0]   row_step;
  logic              col_wrap;
  logic              row_wrap;
  logic              done;

  // Step arithmetic shared by all passes
  assign side_half = (side_mask_i >> 1) + SIDE_W'(1);
  assign half_next = half_step_q >> 1;
  assign half_o    = half_next;
  assign col_step  = {1'b0, cur_col_q} + {1'b0, half_step_q};
  assign row_step  = {1'b0, cur_row_q} + {1'b0, half_step_q};
  assign col_wrap  = col_step > {1'b0, side_mask_i};
  assign row_wrap  = row_step > {1'b0, side_mask_i};

  // Walk state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q      <= PASS_SEED;
      half_step_q <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      dia_half_q  <= 1'b0;
      seed_cnt_q  <= '0;
    end else if (restart_i) begin
      pass_q      <= PASS_SEED;
      half_step_q <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      dia_half_q  <= 1'b0;
      seed_cnt_q  <= '0;
    end else if (step_i) begin
      pass_q      <= pass_d;
      half_step_q <= half_step_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      dia_half_q  <= dia_half_d;
      seed_cnt_q  <= seed_cnt_d;
    end
  end

  // Current point and next walk position
  always_comb begin
    pass_d      = pass_q;
    half_step_d = half_step_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    dia_half_d  = dia_half_q;
    seed_cnt_d  = seed_cnt_q;
    col_o       = '0;
    row_o       = '0;
    done        = 1'b0;

    case (pass_q)
      PASS_SEED: begin
        col_o = seed_cnt_q[0] ? side_half : '0;
        row_o = seed_cnt_q[1] ? side_half : '0;
        if (seed_cnt_q == 2'd3) begin
          // smallest grid: the seeds are the whole map
          if (side_mask_i == SIDE_W'(1)) begin
            done = 1'b1;
          end else begin
            pass_d      = PASS_SQUARE;
            half_step_d = side_half;
            cur_col_d   = side_half >> 1;
            cur_row_d   = side_half >> 1;
          end
        end else begin
          seed_cnt_d = seed_cnt_q + 2'd1;
        end
      end
      PASS_SQUARE: begin
        col_o     = cur_col_q;
        row_o     = cur_row_q;
        cur_col_d = col_step[SIDE_W-1:0];
        if (col_wrap) begin
          cur_col_d = half_next;
          cur_row_d = row_step[SIDE_W-1:0];
          if (row_wrap) begin
            pass_d     = PASS_DIAMOND;
            cur_col_d  = '0;
            cur_row_d  = '0;
            dia_half_d = 1'b0;
          end
        end
      end
      PASS_DIAMOND: begin
        if (!dia_half_q) begin
          col_o      = cur_col_q + half_next;
          row_o      = cur_row_q;
          dia_half_d = 1'b1;
        end else begin
          col_o      = cur_col_q;
          row_o      = cur_row_q + half_next;
          dia_half_d = 1'b0;
          cur_col_d  = col_step[SIDE_W-1:0];
          if (col_wrap) begin
            cur_col_d = '0;
            cur_row_d = row_step[SIDE_W-1:0];
            if (row_wrap) begin
              half_step_d = half_next;
              if (half_next < SIDE_W'(2)) begin
                done = 1'b1;
              end else begin
                pass_d    = PASS_SQUARE;
                cur_col_d = half_next >> 1;
                cur_row_d = half_next >> 1;
              end
            end
          end
        end
      end
      default: begin
        pass_d = PASS_SEED;
      end
    endcase

    // final point: the next request opens a new map
    if (done) begin
      pass_d      = PASS_SEED;
      half_step_d = '0;
      cur_col_d   = '0;
      cur_row_d   = '0;
      dia_half_d  = 1'b0;
      seed_cnt_d  = '0;
    end
  end

  assign ctl_o.kind     = pass_q;
  assign ctl_o.map_done = done;

endmodule

`default_nettype wire

// ----- hdl/diamond_square_terrain_generator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// --------  -------------------------  ---------------------------------------------------
// input     in_valid_i / in_ready_o    rand_draw_i
// output    out_valid_o / out_ready_i  point_col_o, point_row_o, level_o, in_map_o, map_done_o
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each point takes four neighbour reads, one per cycle, through the single read port of
// the height store; the write shares the next cycle. A new request can enter in the last read slot.
// A result passes the read and compute stages and then waits in the output queue.
// Reset clears control and registers only; the height store is never cleared.
// A two-entry result queue lets a request enter while one result waits;
// with two results pending the input is held off.

module diamond_square_terrain_generator_unit
  import dsq_pkg::*;
#(
  parameter int MAX_SIDE   = 256,
  parameter int LEVEL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAND_W-1:0]    rand_draw_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     point_col_o,
  output logic [OUT_W-1:0]     point_row_o,
  output logic [OUT_W-1:0]     level_o,
  output logic                 in_map_o,
  output logic                 map_done_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DIM_W  = ($clog2(MAX_SIDE + 1) > CFG_W) ? $clog2(MAX_SIDE + 1) : CFG_W;
  localparam int CNT_W  = (LEVEL_BITS + 1 > CFG_W) ? LEVEL_BITS + 1 : CFG_W;
  localparam int SUM_W  = LEVEL_BITS + 2;
  localparam int AVG_W  = LEVEL_BITS + 1;
  localparam int PERT_W = ((AVG_W > RAND_W) ? AVG_W : RAND_W) + 2;
  localparam int CMP_W  = (PERT_W > CNT_W) ? PERT_W : CNT_W;

  // Configuration registers
  logic [CFG_W-1:0]   map_width_q, map_height_q, level_count_q;
  logic [ROUGH_W-1:0] roughness_q;
  logic               cfg_acc;
  logic               size_write;

  // Derived map geometry and level range
  logic [DIM_W-1:0]  w_ext, h_ext, w_sat, h_sat, dim_max, dim_m1;
  logic [DIM_W-1:0]  sm1, sm2, sm3, sm4;
  logic [SIDE_W-1:0] side_mask;
  logic [CNT_W-1:0]  lc_ext, lv_max, lv_sat, lv_top;
  logic [CMP_W-1:0]  top_ext;

  // Walker
  logic [SIDE_W-1:0] walk_col, walk_row, walk_half;
  walk_ctl_t         walk_ctl;
  logic              in_acc;
  logic              walk_in_map;

  // Read stage
  logic              a_valid_q;
  logic [1:0]        a_phase_q;
  logic [SIDE_W-1:0] a_col_q, a_row_q, a_h_q;
  pass_e             a_kind_q;
  logic              a_done_q, a_in_map_q;
  logic [RAND_W-1:0] a_draw_q;
  logic [SIDE_W-1:0] col_m, col_p, row_m, row_p, rd_col, rd_row;
  logic [ADDR_W-1:0] raddr;
  logic              a_last;

  // Height store and forwarding
  logic [LEVEL_BITS-1:0] height_mem [DEPTH];
  logic [LEVEL_BITS-1:0] rdata_q;
  logic                  rd_valid_q;
  logic [1:0]            rd_tag_q;
  logic                  fwd_hit_q;
  logic [LEVEL_BITS-1:0] fwd_data_q;
  logic [LEVEL_BITS-1:0] rd_eff;
  logic [SUM_W-1:0]      acc_q;

  // Compute stage
  logic              c_valid_q;
  logic [SIDE_W-1:0] c_col_q, c_row_q;
  pass_e             c_kind_q;
  logic              c_done_q, c_in_map_q;
  logic [RAND_W-1:0] c_draw_q;
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W:0]    sum_p3;
  logic [AVG_W-1:0]  avg;
  logic [PERT_W-1:0] pert;
  logic [CMP_W-1:0]  calc;
  logic [LEVEL_BITS-1:0] val;

  // Result queue
  result_t    q_mem [2];
  result_t    q_head;
  logic       q_wr_q, q_rd_q;
  logic [1:0] q_cnt_q;
  logic       push, pop;
  logic [2:0] busy;

  // Configuration port
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign size_write  = cfg_acc &&
                       (cfg_index_i == REG_MAP_WIDTH || cfg_index_i == REG_MAP_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q   <= RST_MAP_WIDTH;
      map_height_q  <= RST_MAP_HEIGHT;
      level_count_q <= RST_LEVEL_COUNT;
      roughness_q   <= RST_ROUGHNESS;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_MAP_WIDTH:   map_width_q   <= cfg_data_i;
        REG_MAP_HEIGHT:  map_height_q  <= cfg_data_i;
        REG_LEVEL_COUNT: level_count_q <= cfg_data_i;
        REG_ROUGHNESS:   roughness_q   <= cfg_data_i[ROUGH_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated sizes and grid mask (side - 1 of the power-of-two grid)
  assign w_ext   = DIM_W'(map_width_q);
  assign h_ext   = DIM_W'(map_height_q);
  assign w_sat   = (w_ext < DIM_W'(2)) ? DIM_W'(2) :
                   (w_ext > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : w_ext;
  assign h_sat   = (h_ext < DIM_W'(2)) ? DIM_W'(2) :
                   (h_ext > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : h_ext;
  assign dim_max = (w_sat > h_sat) ? w_sat : h_sat;
  assign dim_m1  = dim_max - DIM_W'(1);
  assign sm1     = dim_m1 | (dim_m1 >> 1);
  assign sm2     = sm1 | (sm1 >> 2);
  assign sm3     = sm2 | (sm2 >> 4);
  assign sm4     = sm3 | (sm3 >> 8);
  assign side_mask = SIDE_W'(sm4);

  // Level range
  assign lc_ext  = CNT_W'(level_count_q);
  assign lv_max  = CNT_W'(1) << LEVEL_BITS;
  assign lv_sat  = (lc_ext == '0) ? CNT_W'(1) : (lc_ext > lv_max) ? lv_max : lc_ext;
  assign lv_top  = lv_sat - CNT_W'(1);
  assign top_ext = CMP_W'(lv_top);

  // Point sequencer
  dsq_walker #(
    .SIDE_W(SIDE_W)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (size_write),
    .step_i      (in_acc),
    .side_mask_i (side_mask),
    .col_o       (walk_col),
    .row_o       (walk_row),
    .half_o      (walk_half),
    .ctl_o       (walk_ctl)
  );

  assign walk_in_map = (DIM_W'(walk_col) < w_sat) && (DIM_W'(walk_row) < h_sat);

  // Input handshake: read slot free and room for every result in flight
  assign a_last     = a_phase_q == READ_LAST;
  assign busy       = {2'b00, a_valid_q} + {2'b00, c_valid_q} + {1'b0, q_cnt_q};
  assign in_ready_o = (!a_valid_q || a_last) && (busy <= 3'd1);
  assign in_acc     = in_valid_i && in_ready_o;

  // Read stage: one neighbour read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_phase_q <= '0;
    end else begin
      a_valid_q <= in_acc || (a_valid_q && !a_last);
      if (in_acc) begin
        a_phase_q <= '0;
      end else if (a_valid_q) begin
        a_phase_q <= a_phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_col_q    <= walk_col;
      a_row_q    <= walk_row;
      a_h_q      <= walk_half;
      a_kind_q   <= walk_ctl.kind;
      a_done_q   <= walk_ctl.map_done;
      a_in_map_q <= walk_in_map;
      a_draw_q   <= rand_draw_i;
    end
  end

  // Wrapped neighbour coordinates
  assign col_m = (a_col_q - a_h_q) & side_mask;
  assign col_p = (a_col_q + a_h_q) & side_mask;
  assign row_m = (a_row_q - a_h_q) & side_mask;
  assign row_p = (a_row_q + a_h_q) & side_mask;

  always_comb begin
    rd_col = a_col_q;
    rd_row = a_row_q;
    case (a_kind_q)
      PASS_SQUARE: begin
        // four diagonal corners
        rd_col = a_phase_q[0] ? col_p : col_m;
        rd_row = a_phase_q[1] ? row_p : row_m;
      end
      PASS_DIAMOND: begin
        // left/right, then up/down
        if (!a_phase_q[1]) begin
          rd_col = a_phase_q[0] ? col_p : col_m;
        end else begin
          rd_row = a_phase_q[0] ? row_p : row_m;
        end
      end
      default: ;
    endcase
  end

  assign raddr = {rd_row, rd_col};
  assign waddr = {c_row_q, c_col_q};
  assign push  = c_valid_q;

  // Height store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (push) begin
      height_mem[waddr] <= val;
    end
    if (a_valid_q) begin
      rdata_q <= height_mem[raddr];
    end
  end

  // Read tag and forwarding of a write landing in the same cycle as a read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      rd_tag_q   <= '0;
      fwd_hit_q  <= 1'b0;
    end else begin
      rd_valid_q <= a_valid_q;
      rd_tag_q   <= a_phase_q;
      fwd_hit_q  <= a_valid_q && push && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= val;
  end

  assign rd_eff = fwd_hit_q ? fwd_data_q : rdata_q;

  // Running sum of the first three neighbours
  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_tag_q == 2'd0) begin
        acc_q <= SUM_W'(rd_eff);
      end else if (rd_tag_q != READ_LAST) begin
        acc_q <= acc_q + SUM_W'(rd_eff);
      end
    end
  end

  // Compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= a_valid_q && a_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_last) begin
      c_col_q    <= a_col_q;
      c_row_q    <= a_row_q;
      c_kind_q   <= a_kind_q;
      c_done_q   <= a_done_q;
      c_in_map_q <= a_in_map_q;
      c_draw_q   <= a_draw_q;
    end
  end

  // Ceiling average plus offset, clamped to the level range; a seed takes its clamped draw
  assign sum    = acc_q + SUM_W'(rd_eff);
  assign sum_p3 = {1'b0, sum} + (SUM_W + 1)'(3);
  assign avg    = sum_p3[SUM_W:2];
  assign pert   = PERT_W'(avg) + PERT_W'(c_draw_q) - PERT_W'(roughness_q);

  always_comb begin
    if (c_kind_q == PASS_SEED) begin
      calc = (CMP_W'(c_draw_q) > top_ext) ? top_ext : CMP_W'(c_draw_q);
    end else if (pert[PERT_W-1]) begin
      calc = '0;
    end else if (CMP_W'(pert) > top_ext) begin
      calc = top_ext;
    end else begin
      calc = CMP_W'(pert);
    end
  end

  assign val = LEVEL_BITS'(calc);

  // Result queue
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = q_cnt_q != 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= 1'b0;
      q_rd_q  <= 1'b0;
      q_cnt_q <= '0;
    end else begin
      if (push) begin
        q_wr_q <= ~q_wr_q;
      end
      if (pop) begin
        q_rd_q <= ~q_rd_q;
      end
      q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[q_wr_q].col      <= OUT_W'(c_col_q);
      q_mem[q_wr_q].row      <= OUT_W'(c_row_q);
      q_mem[q_wr_q].level    <= OUT_W'(val);
      q_mem[q_wr_q].in_map   <= c_in_map_q;
      q_mem[q_wr_q].map_done <= c_done_q;
    end
  end

  assign q_head      = q_mem[q_rd_q];
  assign point_col_o = q_head.col;
  assign point_row_o = q_head.row;
  assign level_o     = q_head.level;
  assign in_map_o    = q_head.in_map;
  assign map_done_o  = q_head.map_done;

endmodule

`default_nettype wire

// ----- hdl/dsq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsq_checker
  import dsq_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] point_col_o,
  input logic [OUT_W-1:0] point_row_o,
  input logic [OUT_W-1:0] level_o,
  input logic             in_map_o,
  input logic             map_done_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // A waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A waiting result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(point_col_o) && $stable(point_row_o) &&
      $stable(level_o) && $stable(in_map_o) && $stable(map_done_o))
    else $error("waiting result changed");

  // Four read slots per point: no request is accepted before the last read slot of the previous one
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_acc ##1 !in_acc ##1 !in_acc)
    else $error("request accepted inside the read slots of the previous one");

  // A result reaching an empty queue comes from a request that has passed the read and compute stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc, 6))
    else $error("result appeared without a matching request");

endmodule

bind diamond_square_terrain_generator_unit dsq_checker u_dsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .point_col_o (point_col_o),
  .point_row_o (point_row_o),
  .level_o     (level_o),
  .in_map_o    (in_map_o),
  .map_done_o  (map_done_o)
);

`default_nettype wire

// ----- tb/sv/tb_diamond_square_terrain_generator_unit.sv -----
`timescale 1ns / 1ps

module tb_diamond_square_terrain_generator_unit;
  import dsq_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SIDE_MAX     = 256;
  localparam int LEVEL_MAX    = 256;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Tracks the height map as the block builds it and queues the points it must emit
  class height_map_tracker;
    bit [OUT_W-1:0]   heights [0:SIDE_MAX*SIDE_MAX-1];
    bit [CFG_W-1:0]   width_reg;
    bit [CFG_W-1:0]   height_reg;
    bit [CFG_W-1:0]   levels_reg;
    bit [ROUGH_W-1:0] rough_reg;
    int unsigned      step_len;
    int unsigned      cur_col;
    int unsigned      cur_row;
    int unsigned      seeds;
    bit               lower_next;
    pass_e            phase;
    result_t          pending_points [$];
    int unsigned      errors;

    function new();
      width_reg  = RST_MAP_WIDTH;
      height_reg = RST_MAP_HEIGHT;
      levels_reg = RST_LEVEL_COUNT;
      rough_reg  = RST_ROUGHNESS;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      step_len   = 0;
      phase      = PASS_SEED;
      cur_col    = 0;
      cur_row    = 0;
      lower_next = 1'b0;
      seeds      = 0;
    endfunction

    function int unsigned sat_side(bit [CFG_W-1:0] v);
      if (v < 2) return 2;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    // power-of-two side covering the saturated width and height
    function int unsigned grid_side();
      int unsigned widest;
      int unsigned side;
      widest = (sat_side(width_reg) > sat_side(height_reg)) ? sat_side(width_reg)
                                                             : sat_side(height_reg);
      side = 2;
      while (side < widest) side = side << 1;
      return side;
    endfunction

    function int unsigned level_top();
      if (levels_reg < 1) return 0;
      if (levels_reg > LEVEL_MAX) return LEVEL_MAX - 1;
      return levels_reg - 1;
    endfunction

    // wraparound read
    function int unsigned read_cell(int unsigned side, int unsigned col, int unsigned row);
      return heights[(row & (side - 1)) * side + (col & (side - 1))];
    endfunction

    // ceiling average plus offset, clamped to the level range
    function int unsigned perturb(int unsigned sum, bit [RAND_W-1:0] draw);
      int v;
      v = int'((sum + 3) >> 2) + int'(draw) - int'(rough_reg);
      if (v < 0) v = 0;
      if (v > int'(level_top())) v = level_top();
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
      case (idx)
        REG_MAP_WIDTH: begin
          width_reg = data;
          restart();
        end
        REG_MAP_HEIGHT: begin
          height_reg = data;
          restart();
        end
        REG_LEVEL_COUNT: levels_reg = data;
        REG_ROUGHNESS:   rough_reg = data[ROUGH_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted draw: work out the point it writes and advance the walk
    function void take_draw(bit [RAND_W-1:0] draw);
      int unsigned side;
      int unsigned span;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      int unsigned val;
      int unsigned sum;
      bit          done;
      result_t     point;
      side = grid_side();
      span = step_len;
      h    = step_len >> 1;
      done = 1'b0;
      case (phase)
        PASS_SEED: begin
          col = seeds[0] ? side >> 1 : 0;
          row = seeds[1] ? side >> 1 : 0;
          val = (draw > level_top()) ? level_top() : draw;
          if (seeds >= 3) begin
            if (side <= 2) begin
              done = 1'b1;
            end else begin
              phase    = PASS_SQUARE;
              step_len = side >> 1;
              cur_col  = step_len >> 1;
              cur_row  = step_len >> 1;
            end
          end else begin
            seeds++;
          end
        end
        PASS_SQUARE: begin
          col = cur_col;
          row = cur_row;
          sum = read_cell(side, col + side - h, row + side - h)
              + read_cell(side, col + h, row + side - h)
              + read_cell(side, col + side - h, row + h)
              + read_cell(side, col + h, row + h);
          val = perturb(sum, draw);
          cur_col += span;
          if (cur_col >= side) begin
            cur_col = h;
            cur_row += span;
            if (cur_row >= side) begin
              phase      = PASS_DIAMOND;
              cur_col    = 0;
              cur_row    = 0;
              lower_next = 1'b0;
            end
          end
        end
        default: begin
          // right midpoint, then lower midpoint of the same cell
          if (!lower_next) begin
            col = cur_col + h;
            row = cur_row;
          end else begin
            col = cur_col;
            row = cur_row + h;
          end
          sum = read_cell(side, col + side - h, row)
              + read_cell(side, col + h, row)
              + read_cell(side, col, row + side - h)
              + read_cell(side, col, row + h);
          val = perturb(sum, draw);
          if (!lower_next) begin
            lower_next = 1'b1;
          end else begin
            lower_next = 1'b0;
            cur_col += span;
            if (cur_col >= side) begin
              cur_col = 0;
              cur_row += span;
              if (cur_row >= side) begin
                step_len = span >> 1;
                if (step_len < 2) begin
                  done = 1'b1;
                end else begin
                  phase   = PASS_SQUARE;
                  cur_col = step_len >> 1;
                  cur_row = step_len >> 1;
                end
              end
            end
          end
        end
      endcase
      heights[row * side + col] = val[OUT_W-1:0];
      point.col      = col[OUT_W-1:0];
      point.row      = row[OUT_W-1:0];
      point.level    = val[OUT_W-1:0];
      point.in_map   = (col < sat_side(width_reg)) && (row < sat_side(height_reg));
      point.map_done = done;
      if (done) restart();
      pending_points.push_back(point);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_point(result_t got);
      result_t want;
      if (pending_points.size() == 0) begin
        $error("point col %0d row %0d with no request pending", got.col, got.row);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      compare_field("point_col", want.col, got.col);
      compare_field("point_row", want.row, got.row);
      compare_field("level", want.level, got.level);
      compare_field("in_map", want.in_map, got.in_map);
      compare_field("map_done", want.map_done, got.map_done);
    endfunction
  endclass

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [RAND_W-1:0]    rand_draw = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_W-1:0]     point_col;
  logic [OUT_W-1:0]     point_row;
  logic [OUT_W-1:0]     level;
  logic                 in_map;
  logic                 map_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  height_map_tracker tracker;
  int                send_idle_pct = 29;
  int                recv_idle_pct = 51;
  int unsigned       cycle_count   = 0;

  // directed draws: two 2x2 maps back to back, then one 4x4 map
  int unsigned tiny_map_draws [8]  = '{0, 511, 15, 16, 1, 256, 2, 4};
  int unsigned edge_map_draws [16] = '{0, 511, 128, 255, 511, 0, 255, 256,
                                       300, 200, 511, 0, 1, 510, 254, 257};

  diamond_square_terrain_generator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rand_draw_i (rand_draw),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .point_col_o (point_col),
    .point_row_o (point_row),
    .level_o     (level),
    .in_map_o    (in_map),
    .map_done_o  (map_done),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted points, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      tracker.check_point('{col: point_col, row: point_row, level: level,
                            in_map: in_map, map_done: map_done});
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // mostly small sides, now and then saturated or full-size ones
  function automatic int unsigned pick_side();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return $urandom_range(0, 1);
    if (pick < 70) return $urandom_range(2, 16);
    if (pick < 88) return $urandom_range(17, 32);
    if (pick < 94) return $urandom_range(33, 256);
    return $urandom_range(257, 511);
  endfunction

  // one request, after a random gap
  task automatic send_draw(input logic [RAND_W-1:0] draw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    rand_draw <= draw;
    do @(posedge clk_i); while (!in_ready);
    tracker.take_draw(draw);
  endtask

  // hold requests back until every point has come out and the block is idle
  task automatic drain_points();
    in_valid <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    tracker.set_reg(idx, data[CFG_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned issued;
    int unsigned side;
    int unsigned map_items;
    int unsigned count;
    int unsigned pick;
    int          spread;
    int          d;
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest grid, seed saturation, restart after map done
    write_reg(REG_MAP_WIDTH, 2);
    write_reg(REG_MAP_HEIGHT, 2);
    write_reg(REG_SPARE, 9'h1FF);
    foreach (tiny_map_draws[i]) send_draw(RAND_W'(tiny_map_draws[i]));
    drain_points();

    // 4x4 grid cropped to three columns, full level range, largest roughness
    write_reg(REG_MAP_WIDTH, 3);
    write_reg(REG_MAP_HEIGHT, 4);
    write_reg(REG_LEVEL_COUNT, 256);
    write_reg(REG_ROUGHNESS, 255);
    foreach (edge_map_draws[i]) send_draw(RAND_W'(edge_map_draws[i]));

    // random phases; a phase without a size write carries on mid-map
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued < RANDOM_ITEMS / 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 51;
      end else if (issued < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_points();
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_MAP_WIDTH, pick_side());
        write_reg(REG_MAP_HEIGHT, pick_side());
      end
      pick = $urandom_range(0, 99);
      write_reg(REG_LEVEL_COUNT, (pick < 5)  ? 0 :
                                 (pick < 10) ? 1 :
                                 (pick < 20) ? 256 :
                                 (pick < 25) ? $urandom_range(257, 511) :
                                               $urandom_range(2, 64));
      pick = $urandom_range(0, 99);
      write_reg(REG_ROUGHNESS, (pick < 10) ? 0 :
                               (pick < 20) ? 255 :
                               (pick < 40) ? $urandom_range(0, 255) :
                                             $urandom_range(0, 16));

      // whole small maps, often a partial one after; big grids only in part
      side      = tracker.grid_side();
      map_items = side * side;
      if (map_items <= 256)
        count = map_items * $urandom_range(1, 3)
              + (($urandom_range(0, 3) == 0) ? $urandom_range(1, map_items - 1) : 0);
      else
        count = $urandom_range(16, 300);
      // keep the total near the planned number of requests
      if (count > RANDOM_ITEMS - issued) count = RANDOM_ITEMS - issued;

      spread = $urandom_range(0, 4);
      repeat (count) begin
        if ($urandom_range(0, 3) == 0)
          d = $urandom_range(0, 511);
        else
          d = int'(tracker.rough_reg) + int'($urandom_range(0, 2 * spread)) - spread;
        if (d < 0) d = 0;
        if (d > 511) d = 511;
        send_draw(d[RAND_W-1:0]);
        if ($urandom_range(0, 299) == 0) drain_points();
        issued++;
      end
    end

    drain_points();
    if (tracker.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
